/* src/tvb_pkg.sv */
// Shared types, constants and a lookup function for the target velocity
// and boom angle block. No dependencies.
`default_nettype none

package tvb_pkg;

   localparam int unsigned CORDIC_STEPS = 17;
   localparam int unsigned ROOT_STEPS   = 34;
   localparam int unsigned DIV_STEPS    = 32;

   localparam logic [30:0] MIN_SPEED = 31'd6554;    // 0.1 m/s
   localparam logic [33:0] DEAD_ZONE = 34'd655;     // 0.01 m

   localparam logic [30:0] SPEED_CAP_RST  = 31'd327680;
   localparam logic [30:0] BOOM_REACH_RST = 31'd196608;
   localparam logic [31:0] TIMEOUT_RST    = 32'd500000;

   // csr word index
   localparam logic [1:0] CSR_SPEED_CAP  = 2'd0;
   localparam logic [1:0] CSR_BOOM_REACH = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT    = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_ADD,
      ST_ROOT,
      ST_PREP,
      ST_MUL,
      ST_LOAD,
      ST_DIV,
      ST_ANGLE,
      ST_WAIT
   } tvb_state_type;

   // arctangent of 2^-i in units of 2^-16 rad
   function automatic logic [15:0] atan_lut(input logic [4:0] idx);
      logic [15:0] val;
      unique case (idx)
         5'd0:    val = 16'd51472;
         5'd1:    val = 16'd30386;
         5'd2:    val = 16'd16055;
         5'd3:    val = 16'd8150;
         5'd4:    val = 16'd4091;
         5'd5:    val = 16'd2047;
         5'd6:    val = 16'd1024;
         5'd7:    val = 16'd512;
         5'd8:    val = 16'd256;
         5'd9:    val = 16'd128;
         5'd10:   val = 16'd64;
         5'd11:   val = 16'd32;
         5'd12:   val = 16'd16;
         5'd13:   val = 16'd8;
         5'd14:   val = 16'd4;
         5'd15:   val = 16'd2;
         5'd16:   val = 16'd1;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

/* src/target_velocity_and_boom_angle.sv */
// Top level: setpoint request in, position/velocity/boom angle word out.
// Shares one 33x33 multiplier; square root, divide and CORDIC iterate.
// A stale request is answered in the cycle after it is taken; a fresh one runs
// the square root (34 root steps), two 32-step divides and the CORDIC (17 steps),
// and skips the divides when the distance is inside the dead zone. One request
// at a time: the next one is taken the cycle after the word is taken.
// Synchronous active-high reset clears control and held values and loads the csr registers with their reset values.
`default_nettype none

module target_velocity_and_boom_angle (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic signed [31:0] req_target_x,
   input  wire logic signed [31:0] req_target_y,
   input  wire logic signed [31:0] req_target_z,
   input  wire logic signed [15:0] req_target_yaw,
   input  wire logic signed [15:0] req_target_pitch,
   input  wire logic signed [31:0] req_here_x,
   input  wire logic signed [31:0] req_here_y,
   input  wire logic signed [31:0] req_here_z,
   input  wire logic [30:0]        req_requested_speed,
   input  wire logic               req_request_ok,
   input  wire logic               req_stamp_present,
   input  wire logic [31:0]        req_request_age_us,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_set_x,
   output logic signed [31:0]      rsp_set_y,
   output logic signed [15:0]      rsp_set_heading,
   output logic signed [31:0]      rsp_speed_x,
   output logic signed [31:0]      rsp_speed_y,
   output logic signed [15:0]      rsp_boom_angle,
   output logic signed [15:0]      rsp_bucket_angle,
   output logic                    rsp_setpoint_valid,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import tvb_pkg::*;

   tvb_state_type state_ff, state_in;

   logic [30:0] speed_cap_ff, boom_reach_ff;
   logic [31:0] timeout_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        fresh_ff, fresh_in;
   logic signed [31:0] held_x_ff, held_x_in, held_y_ff, held_y_in;
   logic signed [15:0] held_heading_ff, held_heading_in;
   logic signed [31:0] held_speed_x_ff, held_speed_x_in;
   logic signed [31:0] held_speed_y_ff, held_speed_y_in;
   logic signed [15:0] held_boom_ff, held_boom_in;
   logic signed [15:0] held_bucket_ff, held_bucket_in;

   logic [32:0] ax_ff, ax_in, ay_ff, ay_in;
   logic        negx_ff, negx_in, negy_ff, negy_in;
   logic signed [31:0] tz_ff, tz_in;
   logic [30:0] spd_ff, spd_in;
   logic [30:0] desired_ff, desired_in;
   logic [30:0] reach_ff, reach_in;
   logic [64:0] sum_ff, sum_in;
   logic [65:0] prod_ff, prod_in;
   logic [67:0] rad_ff, rad_in;
   logic [34:0] rem_ff, rem_in;
   logic [33:0] root_ff, root_in;
   logic [34:0] divrem_ff, divrem_in;
   logic [31:0] quo_ff, quo_in;
   logic        sel_ff, sel_in;
   logic [5:0]  cnt_ff, cnt_in;

   logic        accept, fresh_now, csr_wr;
   logic signed [32:0] dx, dy;
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;
   logic [36:0] root_rem2, root_trial;
   logic        root_ge;
   logic [34:0] div_rem2;
   logic        div_ge;
   logic [65:0] num;
   logic [31:0] quot, vel;
   logic        cordic_start, cordic_done;
   logic signed [15:0] cordic_angle;
   logic        root_last, div_last, dead;

   assign accept    = req_valid && req_ready;
   assign fresh_now = req_request_ok && req_stamp_present && (req_request_age_us < timeout_ff);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign root_last = (cnt_ff == 6'(ROOT_STEPS - 1));
   assign div_last  = (cnt_ff == 6'(DIV_STEPS - 1));
   assign dead      = (root_ff <= DEAD_ZONE);

   // shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_SQX:  begin mul_a = ax_ff; mul_b = ax_ff; end
         ST_SQY:  begin mul_a = ay_ff; mul_b = ay_ff; end
         default: begin mul_a = sel_ff ? ay_ff : ax_ff; mul_b = {2'd0, desired_ff}; end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      dx         = 33'(req_target_x) - 33'(req_here_x);
      dy         = 33'(req_target_y) - 33'(req_here_y);
      root_rem2  = {rem_ff, rad_ff[67:66]};
      root_trial = {1'b0, root_ff, 2'b01};
      root_ge    = root_rem2 >= root_trial;
      div_rem2   = {divrem_ff[33:0], quo_ff[31]};
      div_ge     = div_rem2 >= {1'b0, root_ff};
      num        = prod_ff + {33'd0, root_ff[33:1]};
      quot       = {quo_ff[30:0], div_ge};
      vel        = (sel_ff ? negy_ff : negx_ff) ? (32'd0 - quot) : quot;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (accept && fresh_now) state_in = ST_SQX;
         ST_SQX:   state_in = ST_SQY;
         ST_SQY:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_ROOT;
         ST_ROOT:  if (root_last) state_in = ST_PREP;
         ST_PREP:  state_in = dead ? ST_ANGLE : ST_MUL;
         ST_MUL:   state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV:   if (div_last) state_in = sel_ff ? ST_ANGLE : ST_MUL;
         ST_ANGLE: state_in = ST_WAIT;
         ST_WAIT:  if (cordic_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      fresh_in        = fresh_ff;
      held_x_in       = held_x_ff;
      held_y_in       = held_y_ff;
      held_heading_in = held_heading_ff;
      held_speed_x_in = held_speed_x_ff;
      held_speed_y_in = held_speed_y_ff;
      held_boom_in    = held_boom_ff;
      held_bucket_in  = held_bucket_ff;
      ax_in      = ax_ff;
      ay_in      = ay_ff;
      negx_in    = negx_ff;
      negy_in    = negy_ff;
      tz_in      = tz_ff;
      spd_in     = spd_ff;
      desired_in = desired_ff;
      reach_in   = reach_ff;
      sum_in     = sum_ff;
      prod_in    = prod_ff;
      rad_in     = rad_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      divrem_in  = divrem_ff;
      quo_in     = quo_ff;
      sel_in     = sel_ff;
      cnt_in     = cnt_ff;
      cordic_start = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fresh_in = fresh_now;
               if (fresh_now) begin
                  held_x_in       = req_target_x;
                  held_y_in       = req_target_y;
                  held_heading_in = req_target_yaw;
                  held_bucket_in  = req_target_pitch;
                  negx_in = dx[32];
                  negy_in = dy[32];
                  ax_in   = dx[32] ? (33'd0 - dx) : dx;
                  ay_in   = dy[32] ? (33'd0 - dy) : dy;
                  tz_in   = req_target_z;
                  if (req_requested_speed < MIN_SPEED) begin
                     spd_in = MIN_SPEED;
                  end else if (req_requested_speed > speed_cap_ff) begin
                     spd_in = speed_cap_ff;
                  end else begin
                     spd_in = req_requested_speed;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SQX: prod_in = mul_p;
         ST_SQY: begin
            sum_in  = prod_ff[64:0];
            prod_in = mul_p;
         end
         ST_ADD: begin
            rad_in  = {3'd0, sum_ff} + {2'd0, prod_ff};
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
         end
         ST_ROOT: begin
            rem_in  = root_ge ? 35'(root_rem2 - root_trial) : root_rem2[34:0];
            root_in = {root_ff[32:0], root_ge};
            rad_in  = {rad_ff[65:0], 2'b00};
            cnt_in  = cnt_ff + 6'd1;
         end
         ST_PREP: begin
            desired_in = (root_ff < {3'd0, spd_ff}) ? root_ff[30:0] : spd_ff;
            reach_in   = (root_ff < {3'd0, boom_reach_ff}) ? root_ff[30:0] : boom_reach_ff;
            sel_in     = 1'b0;
            if (dead) begin
               held_speed_x_in = '0;
               held_speed_y_in = '0;
            end
         end
         ST_MUL: prod_in = mul_p;
         ST_LOAD: begin
            divrem_in = {1'b0, num[65:32]};
            quo_in    = num[31:0];
            cnt_in    = '0;
         end
         ST_DIV: begin
            divrem_in = div_ge ? (div_rem2 - {1'b0, root_ff}) : div_rem2;
            quo_in    = quot;
            cnt_in    = cnt_ff + 6'd1;
            if (div_last) begin
               if (sel_ff) begin
                  held_speed_y_in = vel;
               end else begin
                  held_speed_x_in = vel;
               end
               sel_in = 1'b1;
            end
         end
         ST_ANGLE: cordic_start = 1'b1;
         ST_WAIT: begin
            if (cordic_done) begin
               held_boom_in = cordic_angle;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         fresh_ff        <= 1'b0;
         held_x_ff       <= '0;
         held_y_ff       <= '0;
         held_heading_ff <= '0;
         held_speed_x_ff <= '0;
         held_speed_y_ff <= '0;
         held_boom_ff    <= '0;
         held_bucket_ff  <= '0;
         speed_cap_ff    <= SPEED_CAP_RST;
         boom_reach_ff   <= BOOM_REACH_RST;
         timeout_ff      <= TIMEOUT_RST;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         fresh_ff        <= fresh_in;
         held_x_ff       <= held_x_in;
         held_y_ff       <= held_y_in;
         held_heading_ff <= held_heading_in;
         held_speed_x_ff <= held_speed_x_in;
         held_speed_y_ff <= held_speed_y_in;
         held_boom_ff    <= held_boom_in;
         held_bucket_ff  <= held_bucket_in;
         if (csr_wr) begin
            unique case (csr_paddr[3:2])
               CSR_SPEED_CAP:  speed_cap_ff  <= csr_pwdata[30:0];
               CSR_BOOM_REACH: boom_reach_ff <= csr_pwdata[30:0];
               CSR_TIMEOUT:    timeout_ff    <= csr_pwdata;
               default: ;
            endcase
         end
      end
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      negx_ff    <= negx_in;
      negy_ff    <= negy_in;
      tz_ff      <= tz_in;
      spd_ff     <= spd_in;
      desired_ff <= desired_in;
      reach_ff   <= reach_in;
      sum_ff     <= sum_in;
      prod_ff    <= prod_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      divrem_ff  <= divrem_in;
      quo_ff     <= quo_in;
      sel_ff     <= sel_in;
      cnt_ff     <= cnt_in;
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_SPEED_CAP:  csr_prdata = {1'b0, speed_cap_ff};
         CSR_BOOM_REACH: csr_prdata = {1'b0, boom_reach_ff};
         CSR_TIMEOUT:    csr_prdata = timeout_ff;
         default:        csr_prdata = '0;
      endcase
   end

   tvb_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .x_in  (reach_ff),
      .y_in  (tz_ff),
      .done  (cordic_done),
      .angle (cordic_angle)
   );

   assign csr_pready         = 1'b1;
   assign req_ready          = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_set_x          = held_x_ff;
   assign rsp_set_y          = held_y_ff;
   assign rsp_set_heading    = held_heading_ff;
   assign rsp_speed_x        = held_speed_x_ff;
   assign rsp_speed_y        = held_speed_y_ff;
   assign rsp_boom_angle     = held_boom_ff;
   assign rsp_bucket_angle   = held_bucket_ff;
   assign rsp_setpoint_valid = fresh_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE) else $error("word shown while busy");
   a_stale_fast: assert property (@(posedge clock) disable iff (reset)
      (accept && !fresh_now) |=> (rsp_valid_ff && !fresh_ff))
      else $error("stale request not answered");
   a_root_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROOT |-> cnt_ff < 6'(ROOT_STEPS)) else $error("root overrun");
   a_div_cnt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> cnt_ff < 6'(DIV_STEPS)) else $error("divide overrun");
   a_done_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT && cordic_done) |=> (rsp_valid_ff && fresh_ff))
      else $error("fresh word lost");

endmodule

`default_nettype wire

/* src/tvb_cordic.sv */
// Iterative vectoring CORDIC: atan2(y, x) for x >= 0, one micro-rotation
// per cycle, result rounded to Q2.13. Depends on tvb_pkg.
`default_nettype none

module tvb_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [30:0]        x_in,
   input  wire logic signed [31:0] y_in,
   output logic                    done,
   output logic signed [15:0]      angle
);
   import tvb_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                zero_ff, zero_in;
   logic [4:0]          step_ff, step_in;
   logic signed [34:0]  x_ff, x_in_nx, y_ff, y_in_nx;
   logic signed [19:0]  z_ff, z_in;
   logic signed [15:0]  angle_ff, angle_in;

   logic signed [34:0]  xs, ys;
   logic signed [19:0]  zn, zr;
   logic signed [19:0]  atan_v;

   always_comb begin
      xs     = x_ff >>> step_ff;
      ys     = y_ff >>> step_ff;
      atan_v = signed'({4'd0, atan_lut(step_ff)});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      zero_in  = zero_ff;
      step_in  = step_ff;
      x_in_nx  = x_ff;
      y_in_nx  = y_ff;
      z_in     = z_ff;
      angle_in = angle_ff;
      if (y_ff >= 0) begin
         zn = z_ff + atan_v;
      end else begin
         zn = z_ff - atan_v;
      end
      zr = (zn + 20'sd4) >>> 3;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         x_in_nx = signed'({4'd0, x_in});
         y_in_nx = 35'(y_in);
         z_in    = '0;
         zero_in = (x_in == '0) && (y_in == '0);
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in_nx = x_ff + ys;
            y_in_nx = y_ff - xs;
         end else begin
            x_in_nx = x_ff - ys;
            y_in_nx = y_ff + xs;
         end
         z_in    = zn;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            angle_in = zero_ff ? '0 : zr[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff  <= zero_in;
      step_ff  <= step_in;
      x_ff     <= x_in_nx;
      y_ff     <= y_in_nx;
      z_ff     <= z_in;
      angle_ff <= angle_in;
   end

   assign done  = done_ff;
   assign angle = angle_ff;

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff < 5'(CORDIC_STEPS)) else $error("cordic step overrun");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("cordic done while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("cordic did not start");

endmodule

`default_nettype wire

/* bench/target_velocity_and_boom_angle_test.sv */
// Self-checking bench for target_velocity_and_boom_angle: directed rows, then
// random setpoint requests over several register settings and idle patterns.
// Depends on src/tvb_pkg.sv, src/target_velocity_and_boom_angle.sv and src/tvb_cordic.sv.
`timescale 1ns / 1ps

module target_velocity_and_boom_angle_test;
   import tvb_pkg::*;

   typedef struct packed {
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
      logic signed [15:0] target_yaw;
      logic signed [15:0] target_pitch;
      logic signed [31:0] here_x;
      logic signed [31:0] here_y;
      logic signed [31:0] here_z;
      logic [30:0]        requested_speed;
      logic               request_ok;
      logic               stamp_present;
      logic [31:0]        request_age_us;
   } request_t;

   typedef struct packed {
      logic signed [31:0] set_x;
      logic signed [31:0] set_y;
      logic signed [15:0] set_heading;
      logic signed [31:0] speed_x;
      logic signed [31:0] speed_y;
      logic signed [15:0] boom_tilt;
      logic signed [15:0] bucket_tilt;
      logic               setpoint_valid;
   } setpoint_t;

   typedef struct {
      request_t  req;
      bit        typed;
      setpoint_t exp;
   } stim_row_t;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam longint ANGLE_STEP [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
      512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   request_t drv = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   wire setpoint_t got;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [3:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   bit drv_typed = 1'b0;
   setpoint_t drv_exp = '0;

   // predictor copy of registers and held word
   logic [30:0] cap_q = SPEED_CAP_RST;
   logic [30:0] reach_q = BOOM_REACH_RST;
   logic [31:0] timeout_q = TIMEOUT_RST;
   setpoint_t held = '0;

   setpoint_t pending_setpoints[$];
   bit failed = 1'b0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned quiet_cycles = 0;

   target_velocity_and_boom_angle u_dut (
      .clock, .reset,
      .req_valid, .req_ready,
      .req_target_x(drv.target_x), .req_target_y(drv.target_y),
      .req_target_z(drv.target_z), .req_target_yaw(drv.target_yaw),
      .req_target_pitch(drv.target_pitch), .req_here_x(drv.here_x),
      .req_here_y(drv.here_y), .req_here_z(drv.here_z),
      .req_requested_speed(drv.requested_speed), .req_request_ok(drv.request_ok),
      .req_stamp_present(drv.stamp_present), .req_request_age_us(drv.request_age_us),
      .rsp_valid, .rsp_ready,
      .rsp_set_x(got.set_x), .rsp_set_y(got.set_y), .rsp_set_heading(got.set_heading),
      .rsp_speed_x(got.speed_x), .rsp_speed_y(got.speed_y),
      .rsp_boom_angle(got.boom_tilt), .rsp_bucket_angle(got.bucket_tilt),
      .rsp_setpoint_valid(got.setpoint_valid),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [33:0] wide_root(input logic [67:0] sum);
      logic [33:0] r;
      logic [67:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = 68'(r | (34'd1 << b));
         if (c * c <= sum) r = c[33:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] scaled_part(input longint d, input longint unsigned desired,
                                               input longint unsigned span);
      longint unsigned a;
      logic [127:0] num;
      longint m;
      a = d < 0 ? longint'(-d) : longint'(d);
      num = 128'(a) * 128'(desired) + 128'(span >> 1);
      m = longint'(num / 128'(span));
      return d < 0 ? 32'(-m) : 32'(m);
   endfunction

   function automatic logic [15:0] boom_arctan(input longint y0, input longint x0);
      longint x, y, z, xs, ys;
      x = x0;
      y = y0;
      z = 0;
      if (x == 0 && y == 0) return '0;
      for (int i = 0; i < 17; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; z += ANGLE_STEP[i];
         end else begin
            x -= ys; y += xs; z -= ANGLE_STEP[i];
         end
      end
      return 16'((z + 4) >>> 3);
   endfunction

   function automatic setpoint_t predict_setpoint(input request_t r);
      longint dx, dy, ax, ay;
      longint unsigned span, spd, desired, reach;
      setpoint_t o;
      if (r.request_ok && r.stamp_present && r.request_age_us < timeout_q) begin
         dx = longint'(r.target_x) - longint'(r.here_x);
         dy = longint'(r.target_y) - longint'(r.here_y);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         span = wide_root(68'(ax) * 68'(ax) + 68'(ay) * 68'(ay));
         if (r.requested_speed < MIN_SPEED) spd = MIN_SPEED;
         else if (r.requested_speed > cap_q) spd = cap_q;
         else spd = r.requested_speed;
         desired = span < spd ? span : spd;
         reach = span < reach_q ? span : reach_q;
         held.set_x = r.target_x;
         held.set_y = r.target_y;
         held.set_heading = r.target_yaw;
         held.bucket_tilt = r.target_pitch;
         if (span > DEAD_ZONE) begin
            held.speed_x = scaled_part(dx, desired, span);
            held.speed_y = scaled_part(dy, desired, span);
         end else begin
            held.speed_x = '0;
            held.speed_y = '0;
         end
         held.boom_tilt = boom_arctan(longint'(r.target_z), longint'(reach));
         o = held;
         o.setpoint_valid = 1'b1;
      end else begin
         o = held;
         o.setpoint_valid = 1'b0;
      end
      return o;
   endfunction

   // request side: accepted word gets its expectation
   always @(negedge clock) begin
      if (!reset && req_valid && req_ready) begin
         setpoint_t p;
         p = predict_setpoint(drv);
         pending_setpoints.push_back(drv_typed ? drv_exp : p);
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_setpoints.size() == 0) begin
            $error("unexpected setpoint word");
            failed = 1'b1;
         end else begin
            setpoint_t e;
            e = pending_setpoints.pop_front();
            if (got.set_x !== e.set_x) begin
               $error("set_x exp %0d got %0d", e.set_x, got.set_x); failed = 1'b1;
            end
            if (got.set_y !== e.set_y) begin
               $error("set_y exp %0d got %0d", e.set_y, got.set_y); failed = 1'b1;
            end
            if (got.set_heading !== e.set_heading) begin
               $error("set_heading exp %0d got %0d", e.set_heading, got.set_heading);
               failed = 1'b1;
            end
            if (got.speed_x !== e.speed_x) begin
               $error("speed_x exp %0d got %0d", e.speed_x, got.speed_x); failed = 1'b1;
            end
            if (got.speed_y !== e.speed_y) begin
               $error("speed_y exp %0d got %0d", e.speed_y, got.speed_y); failed = 1'b1;
            end
            if (got.boom_tilt !== e.boom_tilt) begin
               $error("rsp_boom_angle exp %0d got %0d", e.boom_tilt, got.boom_tilt);
               failed = 1'b1;
            end
            if (got.bucket_tilt !== e.bucket_tilt) begin
               $error("rsp_bucket_angle exp %0d got %0d", e.bucket_tilt, got.bucket_tilt);
               failed = 1'b1;
            end
            if (got.setpoint_valid !== e.setpoint_valid) begin
               $error("setpoint_valid exp %0d got %0d", e.setpoint_valid, got.setpoint_valid);
               failed = 1'b1;
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("target_velocity_and_boom_angle test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_request(input request_t r, input bit typed, input setpoint_t e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      drv <= r;
      drv_typed <= typed;
      drv_exp <= e;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   task automatic drain_setpoints();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_setpoints.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_SPEED_CAP:  cap_q = value[30:0];
         CSR_BOOM_REACH: reach_q = value[30:0];
         default:        timeout_q = value;
      endcase
   endtask

   task automatic set_regs(input logic [31:0] cap, input logic [31:0] reach,
                           input logic [31:0] tmo);
      csr_write(CSR_SPEED_CAP, cap);
      csr_write(CSR_BOOM_REACH, reach);
      csr_write(CSR_TIMEOUT, tmo);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return 32'($urandom_range(2097152)) - 32'd1048576;
         2: begin
            case ($urandom_range(2))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               default: return 32'd0;
            endcase
         end
         default: return 32'($urandom_range(1600000)) - 32'd800000;
      endcase
   endfunction

   function automatic request_t rand_request();
      request_t r;
      r.here_x = rand_coord();
      r.here_y = rand_coord();
      r.here_z = $urandom;
      if ($urandom_range(2) == 0) begin
         // close to here: dead zone and short moves
         r.target_x = r.here_x + (32'($urandom_range(4000)) - 32'd2000);
         r.target_y = r.here_y + (32'($urandom_range(4000)) - 32'd2000);
      end else begin
         r.target_x = rand_coord();
         r.target_y = rand_coord();
      end
      r.target_z = rand_coord();
      r.target_yaw = 16'($urandom_range(51472)) - 16'sd25736;
      r.target_pitch = 16'($urandom_range(51472)) - 16'sd25736;
      case ($urandom_range(3))
         0:       r.requested_speed = 31'($urandom_range(6553));
         1:       r.requested_speed = 31'($urandom_range(600000));
         2:       r.requested_speed = 31'($urandom);
         default: r.requested_speed = cap_q + 31'($urandom_range(2)) - 31'd1;
      endcase
      r.request_ok = $urandom_range(9) != 0;
      r.stamp_present = $urandom_range(9) != 0;
      case ($urandom_range(9))
         0:       r.request_age_us = '0;
         1:       r.request_age_us = $urandom;
         2:       r.request_age_us = timeout_q - 32'($urandom_range(1));
         default: r.request_age_us = $urandom_range(600000);
      endcase
      return r;
   endfunction

   function automatic request_t mk(input logic [31:0] tx, input logic [31:0] ty,
                                   input logic [31:0] tz, input logic [15:0] yaw,
                                   input logic [15:0] pitch, input logic [31:0] hx,
                                   input logic [31:0] hy, input logic [30:0] spd,
                                   input logic ok, input logic stamp, input logic [31:0] age);
      request_t r;
      r = '{target_x: tx, target_y: ty, target_z: tz, target_yaw: yaw, target_pitch: pitch,
            here_x: hx, here_y: hy, here_z: 32'hffff_ffff, requested_speed: spd,
            request_ok: ok, stamp_present: stamp, request_age_us: age};
      return r;
   endfunction

   stim_row_t stim_rows[$];

   initial begin
      stim_row_t row;
      request_t r;
      int unsigned modes [4];
      int unsigned rmodes [4];

      modes = '{0, 69, 0, 9};
      rmodes = '{0, 0, 69, 9};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // held word is zero before any fresh request
      row.req = mk(32'd1, 32'd2, 32'd3, 16'sd100, 16'sd200, 32'd0, 32'd0, 31'd65536,
                   1'b0, 1'b1, 32'd0);
      row.typed = 1'b1; row.exp = '0; stim_rows.push_back(row);
      // no motion, both operands of the boom angle zero
      row.req = mk(32'd77, 32'd99, 32'd0, 16'sd25736, -16'sd25736, 32'd77, 32'd99, 31'd0,
                   1'b1, 1'b1, 32'd0);
      row.exp = '{set_x: 32'sd77, set_y: 32'sd99, set_heading: 16'sd25736,
                  speed_x: 32'sd0, speed_y: 32'sd0, boom_tilt: 16'sd0,
                  bucket_tilt: -16'sd25736, setpoint_valid: 1'b1};
      stim_rows.push_back(row);
      row.typed = 1'b0;
      row.req = mk(32'h7fffffff, 32'h80000000, 32'h7fffffff, -16'sd25736, 16'sd25736,
                   32'h80000000, 32'h7fffffff, 31'h7fffffff, 1'b1, 1'b1, 32'd499999);
      stim_rows.push_back(row);
      row.req = mk(32'h80000000, 32'h7fffffff, 32'h80000000, 16'sd0, 16'sd0,
                   32'h7fffffff, 32'h80000000, 31'd0, 1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      // age equal to the timeout is stale
      row.req = mk(32'd5, 32'd5, 32'd5, 16'sd5, 16'sd5, 32'd0, 32'd0, 31'd65536,
                   1'b1, 1'b1, 32'd500000);
      stim_rows.push_back(row);
      row.req = mk(32'd5, 32'd5, 32'd5, 16'sd5, 16'sd5, 32'd0, 32'd0, 31'd65536,
                   1'b1, 1'b0, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd5, 32'd5, 32'd5, 16'sd5, 16'sd5, 32'd0, 32'd0, 31'd65536,
                   1'b1, 1'b1, 32'hffffffff);
      stim_rows.push_back(row);
      // speed floor, cap, dead-zone edge
      row.req = mk(32'd655360, 32'd0, 32'd65536, 16'sd0, 16'sd0, 32'd0, 32'd0, 31'd6553,
                   1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd0, 32'd655360, 32'd65536, 16'sd0, 16'sd0, 32'd0, 32'd0, 31'h7fffffff,
                   1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd1000, 32'd655, 32'd0, 16'sd0, 16'sd0, 32'd1000, 32'd0, 31'd65536,
                   1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd1000, 32'd656, 32'd0, 16'sd0, 16'sd0, 32'd1000, 32'd0, 31'd65536,
                   1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd300, -32'd400, 32'd0, 16'sd0, 16'sd0, 32'd0, 32'd0, 31'd65536,
                   1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd0, 32'd0, 32'h80000000, 16'sd1, 16'sd1, 32'd0, 32'd0, 31'd65536,
                   1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd0, 32'd0, 32'h7fffffff, 16'sd1, 16'sd1, 32'd0, 32'd0, 31'd65536,
                   1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(-32'd3000000, 32'd2000000, -32'd100000, 16'sd1234, -16'sd4321,
                   32'd10, -32'd10, 31'd327680, 1'b1, 1'b1, 32'd0);
      stim_rows.push_back(row);
      row.req = mk(32'd5, 32'd5, 32'd5, 16'sd5, 16'sd5, 32'd0, 32'd0, 31'd65536,
                   1'b0, 1'b0, 32'd0);
      stim_rows.push_back(row);

      foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].typed,
                                          stim_rows[i].exp);

      for (int p = 0; p < 8; p++) begin
         drain_setpoints();
         case (p)
            0: ;
            1: set_regs(32'd6554, 32'd0, 32'd1);
            2: set_regs(32'h7fffffff, 32'h7fffffff, 32'hffffffff);
            3: set_regs($urandom_range(2000000, 6554), $urandom_range(1000000), 32'd0);
            default: set_regs($urandom_range(2000000, 6554), $urandom & 32'h7fffffff,
                              $urandom_range(700000, 1));
         endcase
         send_idle_pct = modes[p % 4];
         recv_stall_pct = rmodes[p % 4];
         for (int n = 0; n < (p == 3 ? 70 : 205); n++) begin
            if (p == 2 && n == 100) drain_setpoints();
            r = rand_request();
            send_request(r, 1'b0, '0);
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain_setpoints();
      repeat (300) @(posedge clock);
      if (!failed) begin
         $display("target_velocity_and_boom_angle test passed");
      end else begin
         $display("target_velocity_and_boom_angle test failed");
      end
      $finish;
   end

endmodule
